@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define EAUP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define EAUP_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define EAUP_ASSERT(label, clk, rst_n, prop)
`define EAUP_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ hw/rtl/eaup_pkg.sv @@
// ---------------------------------------------------------------------------
// Edge-adaptive 2x row upsampler package
// Request types, the result bundle passed between stages, and constants.
// ---------------------------------------------------------------------------
`default_nettype none

package eaup_pkg;

	localparam int PIXEL_W = 16;
	localparam int OUT_W   = 18;

	// Row position: samples taken in the current row, saturating.
	localparam logic [1:0] POS_START = 2'd0;
	localparam logic [1:0] POS_FULL  = 2'd3;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               row_end;
	} sample_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] pixel_out;
		logic                    row_done;
	} result_t;

	// Up to three results of one input request, emitted v0 first.
	typedef struct packed {
		logic signed [OUT_W-1:0] v2;
		logic signed [OUT_W-1:0] v1;
		logic signed [OUT_W-1:0] v0;
		logic [1:0]              cnt;
		logic                    row_end;
	} bundle_t;

endpackage

`default_nettype wire

@@ hw/rtl/edge_adaptive_2x_row_upsampler.sv @@
// Path: a request is registered at acceptance, its results are formed from that
// register and loaded into the emitter register, which offers the first result.
// Throughput: one result per cycle while result_stall is low. A request gives
// two results mid-row, three at row end, none before; a three-sample row gives one.
// Reset: arst_n clears the window, the row position and all valid flags.
// ---------------------------------------------------------------------------
// Edge-adaptive 2x row upsampler
// Emits each row's inner samples with an edge-aware midpoint between adjacent ones.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module edge_adaptive_2x_row_upsampler #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              sample_valid,
	output logic                   sample_stall,
	input  wire eaup_pkg::sample_t sample,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output eaup_pkg::result_t      result
);

	eaup_pkg::sample_t sample_s1;
	logic              valid_s1;
	eaup_pkg::bundle_t bundle;
	logic [1:0]        pos;
	logic              free;
	logic              advance;
	logic              load;
	logic              accept;

	// Requests with no results retire without waiting on the emitter.
	assign advance      = valid_s1 && ((bundle.cnt == 2'd0) || free);
	assign load         = advance && (bundle.cnt != 2'd0);
	assign sample_stall = valid_s1 && !advance;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
		end
	end

	eaup_window #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.sample (sample_s1),
		.bundle (bundle),
		.pos    (pos)
	);

	eaup_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.bundle_in   (bundle),
		.free        (free),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	`EAUP_ASSERT(a_row_end_restarts, clk, arst_n,
		advance && sample_s1.row_end |=> pos == eaup_pkg::POS_START)
	`EAUP_ASSERT(a_load_offers_result, clk, arst_n, load |=> result_valid)
	`EAUP_ASSERT_NEVER(a_no_overwrite, clk, arst_n, load && result_valid && result_stall)

endmodule

`default_nettype wire

@@ hw/rtl/eaup_interp.sv @@
// ---------------------------------------------------------------------------
// Midpoint interpolator
// Edge-adaptive midpoint between c1 and c2 from a four-sample neighborhood.
// ---------------------------------------------------------------------------
`default_nettype none

module eaup_interp #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic [SAMPLE_BITS-1:0]              c0,
	input  wire logic [SAMPLE_BITS-1:0]              c1,
	input  wire logic [SAMPLE_BITS-1:0]              c2,
	input  wire logic [SAMPLE_BITS-1:0]              c3,
	output logic signed [eaup_pkg::OUT_W-1:0]        mid
);

	// Three times a sample plus sign and headroom for the rounding sum.
	localparam int W    = SAMPLE_BITS + 4;
	localparam int OutW = eaup_pkg::OUT_W;
	localparam logic signed [W-1:0] One = W'(1);
	localparam logic signed [W-1:0] Two = W'(2);

	logic signed [W-1:0] a0, a1, a2, a3;
	logic signed [W-1:0] r, s, t, m, v, q, res;
	logic                use_blend;

	assign a0 = $signed(W'(c0));
	assign a1 = $signed(W'(c1));
	assign a2 = $signed(W'(c2));
	assign a3 = $signed(W'(c3));

	assign r = a1 + a2;
	assign s = (a1 <<< 1) + a1 - a0;
	assign t = (a2 <<< 1) + a2 - a3;

	always_comb begin
		use_blend = 1'b1;
		m         = s;
		priority if (s >= r && t >= r) begin
			m = (s < t) ? s : t;
		end else if (s <= r && t <= r) begin
			m = (s > t) ? s : t;
		end else begin
			use_blend = 1'b0;
		end
	end

	// Divide by four, truncating toward zero for negative sums.
	assign v = r + m + Two;
	always_comb begin
		q = v >>> 2;
		if (v[W-1] && (v[1:0] != 2'b00)) begin
			q = q + One;
		end
	end

	// r is never negative, so the halving is a plain shift.
	assign res = use_blend ? q : ((r + One) >>> 1);
	assign mid = OutW'(res);

endmodule

`default_nettype wire

@@ hw/rtl/eaup_window.sv @@
// ---------------------------------------------------------------------------
// Sample window
// Three-sample window and row position; forms the results of one request.
// ---------------------------------------------------------------------------
`default_nettype none

module eaup_window #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire eaup_pkg::sample_t sample,
	output eaup_pkg::bundle_t      bundle,
	output logic [1:0]             pos
);

	localparam int OutW = eaup_pkg::OUT_W;

	logic [SAMPLE_BITS-1:0] win_q [3];
	logic [1:0]             pos_q;
	logic [SAMPLE_BITS-1:0] p;
	logic signed [OutW-1:0] mid;

	assign p   = SAMPLE_BITS'(sample.pixel);
	assign pos = pos_q;

	eaup_interp #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_interp (
		.c0 (win_q[0]),
		.c1 (win_q[1]),
		.c2 (win_q[2]),
		.c3 (p),
		.mid(mid)
	);

	always_comb begin
		bundle.v0      = $signed(OutW'(win_q[1]));
		bundle.v1      = mid;
		bundle.v2      = $signed(OutW'(win_q[2]));
		bundle.row_end = sample.row_end;
		if (pos_q == eaup_pkg::POS_FULL) begin
			bundle.cnt = sample.row_end ? 2'd3 : 2'd2;
		end else begin
			// A row of exactly three samples gives only its middle sample.
			bundle.cnt = (sample.row_end && pos_q == 2'd2) ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
			pos_q    <= eaup_pkg::POS_START;
		end else if (advance) begin
			if (pos_q == eaup_pkg::POS_FULL) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= p;
				pos_q    <= sample.row_end ? eaup_pkg::POS_START : eaup_pkg::POS_FULL;
			end else begin
				win_q[pos_q] <= p;
				pos_q        <= sample.row_end ? eaup_pkg::POS_START : pos_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/eaup_emit.sv @@
// ---------------------------------------------------------------------------
// Result emitter
// Holds one request's results; sends one per cycle while result_stall is low.
// ---------------------------------------------------------------------------
`default_nettype none

module eaup_emit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire eaup_pkg::bundle_t bundle_in,
	output logic                   free,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output eaup_pkg::result_t      result
);

	eaup_pkg::bundle_t bundle_s2;
	logic              valid_s2;
	logic [1:0]        idx_q;
	logic              last_one;
	logic              taken;

	assign last_one     = (idx_q == bundle_s2.cnt - 2'd1);
	assign taken        = valid_s2 && !result_stall;
	assign free         = !valid_s2 || (taken && last_one);
	assign result_valid = valid_s2;

	always_comb begin
		unique case (idx_q)
			2'd0:    result.pixel_out = bundle_s2.v0;
			2'd1:    result.pixel_out = bundle_s2.v1;
			default: result.pixel_out = bundle_s2.v2;
		endcase
		result.row_done = bundle_s2.row_end && last_one;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= 2'd0;
		end else if (taken) begin
			if (last_one) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_s2 <= bundle_in;
		end
	end

endmodule

`default_nettype wire
